@@ sv/vvh_pkg.sv @@
// Shared constants, types and helpers for the voxel visitation histogram.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package vvh_pkg;

  localparam int DIM_X = 64;
  localparam int DIM_Y = 64;
  localparam int DIM_Z = 64;
  localparam int VOL   = DIM_X * DIM_Y * DIM_Z;
  localparam int IDX_W = $clog2(VOL);

  localparam int COORD_W = 14;
  localparam int VOX_W   = 7;
  localparam int CNT_W   = 32;
  localparam int FRAC_W  = 17;
  localparam int QUO_W   = 16;
  localparam int STEP_W  = $clog2(QUO_W);
  localparam int EPOCH_W = 16;
  localparam int QDEPTH  = 2;

  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [FRAC_W-1:0]  FRAC_ONE  = FRAC_W'(1) << QUO_W;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCOPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd2;

  localparam logic [1:0] SCOPE_ALL  = 2'd0;
  localparam logic [1:0] SCOPE_SEED = 2'd1;
  localparam logic [1:0] SCOPE_ENDS = 2'd2;

  localparam logic ACT_POINT = 1'b0;
  localparam logic ACT_READ  = 1'b1;
  localparam logic SIDE_LEFT = 1'b0;

  typedef struct packed {
    logic             action;
    logic             in_vol;
    logic             sel;
    logic             ends;
    logic [IDX_W-1:0] idx;
  } item_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOOK,
    BK_DIV
  } back_state_t;

  // Round to the nearest voxel, halves up.
  function automatic logic [VOX_W-1:0] to_voxel(input logic [COORD_W-1:0] c);
    logic [COORD_W:0] sum;
    sum = {1'b0, c} + (COORD_W+1)'(128);
    return sum[COORD_W:8];
  endfunction

endpackage

@@ sv/voxel_visitation_histogram.sv @@
// Top level of the voxel visitation histogram: configuration registers and wiring.
// Uses vvh_pkg, vvh_front, vvh_queue and vvh_back.
`timescale 1ns / 1ps

// A point word passes through the back end as a registered read of the count and mark
// memories followed by the write back; the next word is popped only when the last is
// done. A normalised read whose count is below the total then runs through the
// one-bit-per-cycle divider for its sixteen quotient bits. Visited marks are epoch
// tags; after reset, and after every 65535th streamline when the epoch wraps, a pass
// clears all DIM_X*DIM_Y*DIM_Z (262144 by default) marks, and the counts after reset
// only; no word is accepted during the pass after reset.

module voxel_visitation_histogram (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [vvh_pkg::COORD_W-1:0]   in_coord_x,
  input  logic [vvh_pkg::COORD_W-1:0]   in_coord_y,
  input  logic [vvh_pkg::COORD_W-1:0]   in_coord_z,
  input  logic                          in_side,
  input  logic                          in_first_of_side,
  input  logic                          in_last_of_side,
  input  logic                          in_last_of_streamline,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_counted,
  output logic                          out_out_of_range,
  output logic [vvh_pkg::CNT_W-1:0]     out_voxel_count,
  output logic [vvh_pkg::FRAC_W-1:0]    out_fraction,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vvh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vvh_pkg::CNT_W-1:0]     cfg_data
);

  logic [1:0]                scope_r, scope_nxt;
  logic                      norm_r, norm_nxt;
  logic [vvh_pkg::CNT_W-1:0] total_r, total_nxt;
  logic                      push, pop, full, head_valid, clearing;
  vvh_pkg::item_t            push_item, head_item;

  assign cfg_ready = 1'b1;

  always_comb begin
    scope_nxt = scope_r;
    norm_nxt  = norm_r;
    total_nxt = total_r;
    if (cfg_valid) begin
      case (cfg_index)
        vvh_pkg::CFG_SCOPE: scope_nxt = cfg_data[1:0];
        vvh_pkg::CFG_NORM:  norm_nxt  = cfg_data[0];
        vvh_pkg::CFG_TOTAL: total_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scope_r <= vvh_pkg::SCOPE_ALL;
      norm_r  <= 1'b0;
      total_r <= '0;
    end else begin
      scope_r <= scope_nxt;
      norm_r  <= norm_nxt;
      total_r <= total_nxt;
    end
  end

  vvh_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_action,
    .in_coord_x, .in_coord_y, .in_coord_z, .in_side,
    .in_first_of_side, .in_last_of_side, .in_last_of_streamline,
    .scope_mode (scope_r),
    .space_ok   (!full && !clearing),
    .push, .push_item
  );

  vvh_queue u_queue (
    .clk, .rst_n, .push, .push_item, .pop, .full, .head_valid, .head_item
  );

  vvh_back u_back (
    .clk, .rst_n, .head_valid, .head_item, .pop, .clearing,
    .normalise_enable  (norm_r),
    .total_streamlines (total_r),
    .out_valid, .out_ready, .out_counted, .out_out_of_range,
    .out_voxel_count, .out_fraction
  );

endmodule

@@ sv/vvh_front.sv @@
// Front end: takes input words, locates the voxel and applies the scope rule.
// Uses vvh_pkg; feeds vvh_queue.
`timescale 1ns / 1ps

module vvh_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [vvh_pkg::COORD_W-1:0] in_coord_x,
  input  logic [vvh_pkg::COORD_W-1:0] in_coord_y,
  input  logic [vvh_pkg::COORD_W-1:0] in_coord_z,
  input  logic                        in_side,
  input  logic                        in_first_of_side,
  input  logic                        in_last_of_side,
  input  logic                        in_last_of_streamline,
  input  logic [1:0]                  scope_mode,
  input  logic                        space_ok,
  output logic                        push,
  output vvh_pkg::item_t              push_item
);

  logic                      left_seen_r, left_seen_nxt;
  logic [vvh_pkg::VOX_W-1:0] vx, vy, vz;
  logic [31:0]               idx_full;
  logic                      in_vol, right, sel, is_point;

  assign in_ready = space_ok;
  assign push     = in_valid && in_ready;

  always_comb begin
    vx = vvh_pkg::to_voxel(in_coord_x);
    vy = vvh_pkg::to_voxel(in_coord_y);
    vz = vvh_pkg::to_voxel(in_coord_z);
    in_vol = (32'(vx) < 32'(vvh_pkg::DIM_X)) && (32'(vy) < 32'(vvh_pkg::DIM_Y)) &&
             (32'(vz) < 32'(vvh_pkg::DIM_Z));
    idx_full = (32'(vz) * 32'(vvh_pkg::DIM_Y) + 32'(vy)) * 32'(vvh_pkg::DIM_X) + 32'(vx);
    right    = (in_side != vvh_pkg::SIDE_LEFT);
    is_point = (in_action == vvh_pkg::ACT_POINT);
    case (scope_mode)
      vvh_pkg::SCOPE_ALL:  sel = 1'b1;
      vvh_pkg::SCOPE_SEED: sel = in_first_of_side && (!right || !left_seen_r);
      vvh_pkg::SCOPE_ENDS: sel = in_last_of_side;
      default:             sel = 1'b0;
    endcase
    push_item.action = in_action;
    push_item.in_vol = in_vol;
    push_item.sel    = sel && is_point;
    push_item.ends   = in_last_of_streamline && is_point;
    push_item.idx    = idx_full[vvh_pkg::IDX_W-1:0];

    left_seen_nxt = left_seen_r;
    if (push && is_point) begin
      if (in_last_of_streamline) begin
        left_seen_nxt = 1'b0;
      end else if (!right) begin
        left_seen_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_seen_r <= 1'b0;
    end else begin
      left_seen_r <= left_seen_nxt;
    end
  end

endmodule

@@ sv/vvh_queue.sv @@
// Short FIFO of classified items between the front and back ends.
// Uses vvh_pkg for the item type and depth.
`timescale 1ns / 1ps

module vvh_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vvh_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output vvh_pkg::item_t head_item
);

  localparam int PTR_W = $clog2(vvh_pkg::QDEPTH);
  localparam int CNT_W = $clog2(vvh_pkg::QDEPTH + 1);

  vvh_pkg::item_t   slot_r [vvh_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  assign full       = (fill_r == CNT_W'(vvh_pkg::QDEPTH));
  assign head_valid = (fill_r != '0);
  assign head_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ sv/vvh_back.sv @@
// Back end: count and mark memories, read-modify-write, serial divider, result word.
// Uses vvh_pkg; pops items from vvh_queue.
`timescale 1ns / 1ps

module vvh_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        head_valid,
  input  vvh_pkg::item_t              head_item,
  output logic                        pop,
  output logic                        clearing,
  input  logic                        normalise_enable,
  input  logic [vvh_pkg::CNT_W-1:0]   total_streamlines,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_counted,
  output logic                        out_out_of_range,
  output logic [vvh_pkg::CNT_W-1:0]   out_voxel_count,
  output logic [vvh_pkg::FRAC_W-1:0]  out_fraction
);

  logic [vvh_pkg::CNT_W-1:0]   cnt_mem  [vvh_pkg::VOL];
  logic [vvh_pkg::EPOCH_W-1:0] mark_mem [vvh_pkg::VOL];
  logic [vvh_pkg::CNT_W-1:0]   cnt_rd_r;
  logic [vvh_pkg::EPOCH_W-1:0] mark_rd_r;

  vvh_pkg::back_state_t state_r, state_nxt;
  vvh_pkg::item_t       item_r;
  logic [vvh_pkg::IDX_W-1:0]   sweep_r, sweep_nxt;
  logic                        clr_cnt_r, clr_cnt_nxt;
  logic [vvh_pkg::EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [vvh_pkg::CNT_W-1:0]   rem_r, rem_nxt;
  logic [vvh_pkg::QUO_W-1:0]   quo_r, quo_nxt;
  logic [vvh_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                        ov_r, ov_nxt, oc_r, oc_nxt, oo_r, oo_nxt;
  logic [vvh_pkg::CNT_W-1:0]   ocnt_r, ocnt_nxt;
  logic [vvh_pkg::FRAC_W-1:0]  ofr_r, ofr_nxt;

  logic                        sweep_done, upd, inc, need_div, wrap;
  logic                        cnt_we, mark_we;
  logic [vvh_pkg::IDX_W-1:0]   wr_addr;
  logic [vvh_pkg::CNT_W-1:0]   cnt_wd;
  logic [vvh_pkg::EPOCH_W-1:0] mark_wd;
  logic [vvh_pkg::CNT_W:0]     rem2;
  logic                        ge;

  assign out_valid        = ov_r;
  assign out_counted      = oc_r;
  assign out_out_of_range = oo_r;
  assign out_voxel_count  = ocnt_r;
  assign out_fraction     = ofr_r;
  assign clearing         = (state_r == vvh_pkg::BK_CLEAR) && clr_cnt_r;

  // A voxel is visited in this streamline when its mark equals the current epoch.
  always_comb begin
    sweep_done = (sweep_r == vvh_pkg::IDX_W'(vvh_pkg::VOL - 1));
    upd  = item_r.sel && item_r.in_vol && (mark_rd_r != epoch_r);
    inc  = upd && (cnt_rd_r != vvh_pkg::CNT_MAX);
    need_div = normalise_enable && item_r.in_vol && (total_streamlines != '0) &&
               (cnt_rd_r < total_streamlines);
    wrap = item_r.ends && (epoch_r == vvh_pkg::EPOCH_MAX);
    pop  = (state_r == vvh_pkg::BK_IDLE) && head_valid && (!ov_r || out_ready);
    rem2 = {rem_r, 1'b0};
    ge   = (rem2 >= {1'b0, total_streamlines});
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vvh_pkg::BK_CLEAR: begin
        if (sweep_done) state_nxt = vvh_pkg::BK_IDLE;
      end
      vvh_pkg::BK_IDLE: begin
        if (pop) state_nxt = vvh_pkg::BK_LOOK;
      end
      vvh_pkg::BK_LOOK: begin
        if (item_r.action == vvh_pkg::ACT_READ) begin
          state_nxt = need_div ? vvh_pkg::BK_DIV : vvh_pkg::BK_IDLE;
        end else begin
          state_nxt = wrap ? vvh_pkg::BK_CLEAR : vvh_pkg::BK_IDLE;
        end
      end
      vvh_pkg::BK_DIV: begin
        if (step_r == vvh_pkg::STEP_W'(vvh_pkg::QUO_W - 1)) state_nxt = vvh_pkg::BK_IDLE;
      end
      default: state_nxt = vvh_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    sweep_nxt   = sweep_r;
    clr_cnt_nxt = clr_cnt_r;
    epoch_nxt   = epoch_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    step_nxt    = step_r;
    ov_nxt      = ov_r && !out_ready;
    oc_nxt      = oc_r;
    oo_nxt      = oo_r;
    ocnt_nxt    = ocnt_r;
    ofr_nxt     = ofr_r;
    cnt_we      = 1'b0;
    mark_we     = 1'b0;
    wr_addr     = item_r.idx;
    cnt_wd      = cnt_rd_r + vvh_pkg::CNT_W'(1);
    mark_wd     = epoch_r;
    case (state_r)
      vvh_pkg::BK_CLEAR: begin
        wr_addr   = sweep_r;
        cnt_wd    = '0;
        mark_wd   = '0;
        mark_we   = 1'b1;
        cnt_we    = clr_cnt_r;
        sweep_nxt = sweep_r + vvh_pkg::IDX_W'(1);
        if (sweep_done) begin
          sweep_nxt   = '0;
          clr_cnt_nxt = 1'b0;
        end
      end
      vvh_pkg::BK_LOOK: begin
        oo_nxt = !item_r.in_vol;
        if (item_r.action == vvh_pkg::ACT_READ) begin
          oc_nxt   = 1'b0;
          ocnt_nxt = item_r.in_vol ? cnt_rd_r : '0;
          ofr_nxt  = (normalise_enable && item_r.in_vol) ? vvh_pkg::FRAC_ONE : '0;
          rem_nxt  = cnt_rd_r;
          quo_nxt  = '0;
          step_nxt = '0;
          ov_nxt   = !need_div;
        end else begin
          mark_we  = upd;
          cnt_we   = inc;
          oc_nxt   = inc;
          ocnt_nxt = '0;
          ofr_nxt  = '0;
          ov_nxt   = 1'b1;
          if (item_r.ends) begin
            epoch_nxt = wrap ? vvh_pkg::EPOCH_FIRST : epoch_r + vvh_pkg::EPOCH_W'(1);
          end
        end
      end
      vvh_pkg::BK_DIV: begin
        rem_nxt  = ge ? vvh_pkg::CNT_W'(rem2 - {1'b0, total_streamlines})
                      : rem2[vvh_pkg::CNT_W-1:0];
        quo_nxt  = {quo_r[vvh_pkg::QUO_W-2:0], ge};
        step_nxt = step_r + vvh_pkg::STEP_W'(1);
        if (step_r == vvh_pkg::STEP_W'(vvh_pkg::QUO_W - 1)) begin
          ofr_nxt = {1'b0, quo_nxt};
          ov_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= vvh_pkg::BK_CLEAR;
      sweep_r   <= '0;
      clr_cnt_r <= 1'b1;
      epoch_r   <= vvh_pkg::EPOCH_FIRST;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sweep_r   <= sweep_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      epoch_r   <= epoch_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) item_r <= head_item;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
    oc_r   <= oc_nxt;
    oo_r   <= oo_nxt;
    ocnt_r <= ocnt_nxt;
    ofr_r  <= ofr_nxt;
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[wr_addr] <= cnt_wd;
    cnt_rd_r <= cnt_mem[head_item.idx];
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[wr_addr] <= mark_wd;
    mark_rd_r <= mark_mem[head_item.idx];
  end

endmodule

@@ sv/vvh_checker.sv @@
// Port-level checks for voxel_visitation_histogram, attached by bind.
// Uses vvh_pkg for widths and the saturated fraction value.
`timescale 1ns / 1ps

module vvh_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_counted,
  input logic                         out_out_of_range,
  input logic [vvh_pkg::CNT_W-1:0]    out_voxel_count,
  input logic [vvh_pkg::FRAC_W-1:0]   out_fraction
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_voxel_count) &&
    $stable(out_fraction) && $stable(out_counted))
    else $error("stalled result word changed");

  a_counted_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_counted |-> !out_out_of_range && out_voxel_count == '0 &&
    out_fraction == '0)
    else $error("counted point word carries read data");

  a_frac_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fraction <= vvh_pkg::FRAC_ONE)
    else $error("fraction above one");

  a_oor_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> !out_counted && out_voxel_count == '0 &&
    out_fraction == '0)
    else $error("out-of-volume word carries data");

endmodule

bind voxel_visitation_histogram vvh_checker u_vvh_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_counted, .out_out_of_range,
  .out_voxel_count, .out_fraction
);
